// ===== hdl/tpq_pkg.sv =====
// Shared types and constants for the two-class priority queue.
// Holds the operation, status, cell command and sequencer state codes.
// No dependencies; every other file in hdl imports this package.
`default_nettype none

package tpq_pkg;

    // Width of the key and key_out ports.
    localparam int KEY_W = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_POP    = 3'd2,
        CELL_MATCH  = 3'd3,
        CELL_SCAN   = 3'd4,
        CELL_REMOVE = 3'd5
    } cell_cmd_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_SCAN = 1'b1
    } seq_state_t;

    // One result transaction, less the occupancy which follows the depth.
    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] key_out;
        logic             urgent_out;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/tpq_cell.sv =====
// One queue slot of the two-class priority queue chain.
// Holds a key and the match flags used while a remove scans the chain.
// Depends on tpq_pkg.
`default_nettype none

module tpq_cell #(
    parameter int KW  = 16,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tpq_pkg::cell_cmd_t  cmd,
    input  wire logic [CW-1:0]       pos,
    input  wire logic [CW-1:0]       held,
    input  wire logic [CW-1:0]       urg_cnt,
    input  wire logic [KW-1:0]       key_new,
    input  wire logic [KW-1:0]       left_key,
    input  wire logic [KW-1:0]       right_key,
    input  wire logic                left_flag,
    input  wire logic                left_uflag,
    output logic [KW-1:0]            key_q,
    output logic                     flag_q,
    output logic                     uflag_q
);
    import tpq_pkg::*;

    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    logic [KW-1:0] key_reg;
    logic [KW-1:0] key_next;
    logic          flag_reg;
    logic          flag_next;
    logic          uflag_reg;
    logic          uflag_next;
    logic          occupied;
    logic          hit;

    assign occupied = (MY_POS < held);
    assign hit      = occupied && (key_reg == key_new);

    always_comb
    begin
        key_next   = key_reg;
        flag_next  = flag_reg;
        uflag_next = uflag_reg;
        case (cmd)
            CELL_INSERT:
            begin
                if (MY_POS == pos)
                begin
                    key_next = key_new;
                end
                else if (MY_POS > pos)
                begin
                    key_next = left_key;
                end
            end
            CELL_POP:
            begin
                key_next = right_key;
            end
            CELL_MATCH:
            begin
                flag_next  = hit;
                uflag_next = hit && (MY_POS < urg_cnt);
            end
            CELL_SCAN:
            begin
                flag_next  = flag_reg | left_flag;
                uflag_next = uflag_reg | left_uflag;
            end
            CELL_REMOVE:
            begin
                // Every slot at or behind the first match closes the gap.
                if (flag_reg)
                begin
                    key_next = right_key;
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg  <= 1'b0;
            uflag_reg <= 1'b0;
        end
        else
        begin
            flag_reg  <= flag_next;
            uflag_reg <= uflag_next;
        end
    end

    assign key_q   = key_reg;
    assign flag_q  = flag_reg;
    assign uflag_q = uflag_reg;

endmodule

`default_nettype wire

// ===== hdl/two_class_priority_queue_core.sv =====
// Top level of the two-class priority queue: a chain of tpq_cell slots,
// the count registers, the remove sequencer and a two-deep result buffer.
// Depends on tpq_pkg and tpq_cell.
//
// Usage: a request transaction (op, key, urgent) is taken on req_valid when
// req_stall is low; each request gives exactly one response transaction
// (status, key_out, urgent_out, occupancy) on rsp_valid, held until the
// receiver lowers rsp_stall. Insert, pop and the unused op code finish in
// the cycle they are accepted, so their response is registered into the
// output register, or into the skid register while the receiver stalls,
// and a new request may follow in the very next cycle. Remove runs in three
// steps: a compare of every slot against the key, a scan in which the match
// flags travel one cell per cycle down the chain so that each slot learns
// whether a match lies at or ahead of it, and a last step to close the gap.
// No request is taken while a remove is in progress. Responses pass through
// an output register and a skid register, so a request is still taken while
// one finished response waits on a stalled receiver; with both full,
// req_stall rises. Reset empties the queue and the response buffer at once;
// slot keys are not cleared, since only slots below the held count are read.
`default_nettype none

module two_class_priority_queue_core #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [1:0]                    op,
    input  wire logic [tpq_pkg::KEY_W-1:0]     key,
    input  wire logic                          urgent,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic [1:0]                         status,
    output logic [tpq_pkg::KEY_W-1:0]          key_out,
    output logic                               urgent_out,
    output logic [$clog2(DEPTH+1)-1:0]         occupancy
);
    import tpq_pkg::*;

    // Only the low bits of the key port that the stored key holds are used.
    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] SCAN_END = SW'(DEPTH - 1);

    // Queue counts and sequencer.
    logic [CW-1:0] held_reg;
    logic [CW-1:0] held_next;
    logic [CW-1:0] urg_reg;
    logic [CW-1:0] urg_next;
    seq_state_t    state_reg;
    seq_state_t    state_next;
    logic [SW-1:0] scan_reg;
    logic [SW-1:0] scan_next;
    logic [KW-1:0] srch_reg;
    logic [KW-1:0] srch_next;

    // Chain wiring.
    cell_cmd_t     cmd;
    logic [CW-1:0] ins_pos;
    logic [KW-1:0] key_in;
    logic [KW-1:0] cell_key [DEPTH];
    logic [DEPTH-1:0] cell_flag;
    logic [DEPTH-1:0] cell_uflag;

    // Response produced this cycle and the two-deep response buffer.
    logic          res_valid;
    rsp_t          res;
    logic [CW-1:0] res_occ;
    logic          out_valid_reg;
    logic          out_valid_next;
    rsp_t          out_rsp_reg;
    rsp_t          out_rsp_next;
    logic [CW-1:0] out_occ_reg;
    logic [CW-1:0] out_occ_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    rsp_t          skid_rsp_reg;
    rsp_t          skid_rsp_next;
    logic [CW-1:0] skid_occ_reg;
    logic [CW-1:0] skid_occ_next;

    logic          accept;
    logic          found;
    logic          urg_hit;

    assign key_in    = key[KW-1:0];
    assign req_stall = (state_reg != SEQ_IDLE) || skid_valid_reg;
    assign accept    = req_valid && !req_stall;
    assign found     = cell_flag[DEPTH-1];
    assign urg_hit   = cell_uflag[DEPTH-1];

    // Sequencer, count update and response generation.
    always_comb
    begin
        held_next  = held_reg;
        urg_next   = urg_reg;
        state_next = state_reg;
        scan_next  = scan_reg;
        srch_next  = srch_reg;
        cmd        = CELL_HOLD;
        ins_pos    = held_reg;
        res_valid  = 1'b0;
        res        = '{status: STAT_DONE, key_out: '0, urgent_out: 1'b0};
        res_occ    = held_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    res_valid = 1'b1;
                    case (op_t'(op))
                        OP_INSERT:
                        begin
                            if (held_reg == FULL_CNT)
                            begin
                                res.status = STAT_FULL;
                            end
                            else
                            begin
                                cmd       = CELL_INSERT;
                                ins_pos   = urgent ? urg_reg : held_reg;
                                held_next = held_reg + CW'(1);
                                urg_next  = urg_reg + CW'(urgent);
                                res_occ   = held_next;
                            end
                        end
                        OP_POP:
                        begin
                            if (held_reg == '0)
                            begin
                                res.status = STAT_MISS;
                            end
                            else
                            begin
                                cmd            = CELL_POP;
                                res.key_out    = KEY_W'(cell_key[0]);
                                res.urgent_out = (urg_reg != '0);
                                held_next      = held_reg - CW'(1);
                                urg_next       = urg_reg - CW'(urg_reg != '0);
                                res_occ        = held_next;
                            end
                        end
                        OP_REMOVE:
                        begin
                            // The response follows once the scan completes.
                            res_valid  = 1'b0;
                            cmd        = CELL_MATCH;
                            srch_next  = key_in;
                            scan_next  = '0;
                            state_next = SEQ_SCAN;
                        end
                        default:
                        begin
                            res.status = STAT_DONE;
                        end
                    endcase
                end
            end
            SEQ_SCAN:
            begin
                if (scan_reg == SCAN_END)
                begin
                    cmd        = CELL_REMOVE;
                    res_valid  = 1'b1;
                    state_next = SEQ_IDLE;
                    if (found)
                    begin
                        res.key_out    = KEY_W'(srch_reg);
                        res.urgent_out = urg_hit;
                        held_next      = held_reg - CW'(1);
                        urg_next       = urg_reg - CW'(urg_hit);
                        res_occ        = held_next;
                    end
                    else
                    begin
                        res.status = STAT_MISS;
                    end
                end
                else
                begin
                    cmd       = CELL_SCAN;
                    scan_next = scan_reg + SW'(1);
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Response buffer: the output register is refilled from the skid
    // register first, so transactions leave in the order they were made.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_rsp_next    = out_rsp_reg;
        out_occ_next    = out_occ_reg;
        skid_valid_next = skid_valid_reg;
        skid_rsp_next   = skid_rsp_reg;
        skid_occ_next   = skid_occ_reg;
        if (!out_valid_reg || !rsp_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_rsp_next    = skid_rsp_reg;
                out_occ_next    = skid_occ_reg;
                skid_valid_next = res_valid;
                skid_rsp_next   = res;
                skid_occ_next   = res_occ;
            end
            else
            begin
                out_valid_next = res_valid;
                out_rsp_next   = res;
                out_occ_next   = res_occ;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_rsp_next   = res;
            skid_occ_next   = res_occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            urg_reg        <= '0;
            state_reg      <= SEQ_IDLE;
            scan_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg       <= held_next;
            urg_reg        <= urg_next;
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        srch_reg     <= srch_next;
        out_rsp_reg  <= out_rsp_next;
        out_occ_reg  <= out_occ_next;
        skid_rsp_reg <= skid_rsp_next;
        skid_occ_reg <= skid_occ_next;
    end

    // The chain: slot 0 is the head. Keys move right on insert and left on
    // pop or remove; match flags move right during the scan.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KW-1:0] left_key;
        logic [KW-1:0] right_key;
        logic          left_flag;
        logic          left_uflag;

        if (i == 0)
        begin : g_head
            assign left_key   = '0;
            assign left_flag  = 1'b0;
            assign left_uflag = 1'b0;
        end
        else
        begin : g_body
            assign left_key   = cell_key[i-1];
            assign left_flag  = cell_flag[i-1];
            assign left_uflag = cell_uflag[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_key = cell_key[i];
        end
        else
        begin : g_inner
            assign right_key = cell_key[i+1];
        end

        tpq_cell #(
            .KW  (KW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .pos        (ins_pos),
            .held       (held_reg),
            .urg_cnt    (urg_reg),
            .key_new    ((state_reg == SEQ_IDLE) ? key_in : srch_reg),
            .left_key   (left_key),
            .right_key  (right_key),
            .left_flag  (left_flag),
            .left_uflag (left_uflag),
            .key_q      (cell_key[i]),
            .flag_q     (cell_flag[i]),
            .uflag_q    (cell_uflag[i])
        );
    end

    assign rsp_valid  = out_valid_reg;
    assign status     = out_rsp_reg.status;
    assign key_out    = out_rsp_reg.key_out;
    assign urgent_out = out_rsp_reg.urgent_out;
    assign occupancy  = out_occ_reg;

endmodule

`default_nettype wire
